@@ rtl/cpa_pkg.sv @@
package cpa_pkg;

    localparam int NumChunks       = 256;
    localparam int ChunkIdxW       = $clog2(NumChunks);
    localparam int RunLenW         = $clog2(NumChunks + 1);
    localparam int ChunkBytesW     = 13;
    localparam int ChunkBytesReset = 64;
    localparam int ChunkBytesMax   = 4096;
    localparam int SizeW           = 21;
    localparam int AddrW           = 20;
    localparam int BytesW          = 21;
    // dividend holds size + chunk_bytes - 1 without overflow
    localparam int DivW            = SizeW + 1;
    localparam int DivCntW         = $clog2(DivW);
    localparam int MulW            = RunLenW + ChunkBytesW;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_ZERO     = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type        req_type;
        logic [SizeW-1:0] size_bytes;
        logic [AddrW-1:0] address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [AddrW-1:0]  granted_address;
        logic [BytesW-1:0] granted_bytes;
        logic [BytesW-1:0] used_bytes;
    } t_rsp;

endpackage

@@ rtl/chunk_pool_allocator.sv @@
// channel    direction  handshake                  payload
// config     in         i_cfg_we                   i_cfg_wdata (chunk bytes)
// request    in         i_in_valid / o_in_ready    i_in_data  (cpa_pkg::t_req)
// response   out        o_out_valid / i_out_ready  o_out_data (cpa_pkg::t_rsp)
//
// One request at a time. Every request but a zero-size allocate runs the bit-serial divider.
// Allocate scans one chunk a cycle from the cursor to the top of the pool, and again from
// chunk 0 if needed, then marks one chunk a cycle (run length). Free reads the run length
// memory and clears one chunk a cycle. Three multiply steps (S_MUL_A, S_MUL_B, S_MUL_U) and
// the output state S_OUT follow. Synchronous reset frees every chunk at once. A stalled
// response holds the block in S_OUT; the next request is taken while one response waits.
module chunk_pool_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpa_pkg::ChunkBytesW-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cpa_pkg::t_req                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cpa_pkg::t_rsp                   o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_CLEAR,
        S_MUL_A,
        S_MUL_B,
        S_MUL_U,
        S_OUT
    } t_state;

    t_state                            r_state;
    logic [cpa_pkg::ChunkBytesW-1:0]   r_cb;
    logic [cpa_pkg::NumChunks-1:0]     r_busy;
    logic [cpa_pkg::NumChunks-1:0]     r_head_vld;
    logic [cpa_pkg::RunLenW-1:0]       r_run_mem [cpa_pkg::NumChunks];
    logic [cpa_pkg::RunLenW-1:0]       r_run_rd;
    logic [cpa_pkg::ChunkIdxW-1:0]     r_cursor;
    logic [cpa_pkg::RunLenW-1:0]       r_used;
    cpa_pkg::t_req_type                r_req_type;
    cpa_pkg::t_status                  r_status;
    logic [cpa_pkg::ChunkIdxW-1:0]     r_start;
    logic [cpa_pkg::ChunkIdxW-1:0]     r_pos;
    logic [cpa_pkg::RunLenW-1:0]       r_len;
    logic [cpa_pkg::RunLenW-1:0]       r_left;
    logic [cpa_pkg::RunLenW-1:0]       r_run;
    logic                              r_wrapped;
    logic [cpa_pkg::AddrW-1:0]         r_gaddr;
    logic [cpa_pkg::BytesW-1:0]        r_gbytes;
    logic [cpa_pkg::BytesW-1:0]        r_ubytes;
    logic                              r_out_vld;
    cpa_pkg::t_rsp                     r_out;

    logic                              n_accept;
    logic                              n_div_start;
    logic [cpa_pkg::DivW-1:0]          n_dividend;
    logic                              div_done;
    logic [cpa_pkg::DivW-1:0]          div_q;
    logic [cpa_pkg::ChunkBytesW-1:0]   div_r;
    logic [cpa_pkg::ChunkBytesW-1:0]   n_cfg;
    logic [cpa_pkg::RunLenW-1:0]       n_run;
    logic [cpa_pkg::ChunkIdxW-1:0]     n_start;
    logic [cpa_pkg::RunLenW-1:0]       mul_a;
    logic [cpa_pkg::MulW-1:0]          mul_p;
    logic                              n_ok;

    assign n_accept = i_in_valid && o_in_ready;
    assign n_div_start = n_accept &&
        !(i_in_data.req_type == cpa_pkg::REQ_ALLOC && i_in_data.size_bytes == '0);

    always_comb begin
        if (i_in_data.req_type == cpa_pkg::REQ_ALLOC) begin
            n_dividend = cpa_pkg::DivW'(i_in_data.size_bytes) + cpa_pkg::DivW'(r_cb)
                         - cpa_pkg::DivW'(1);
        end else begin
            n_dividend = cpa_pkg::DivW'(i_in_data.address);
        end
    end

    cpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (n_dividend),
        .i_divisor   (r_cb),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // clamp chunk size into its legal range
    always_comb begin
        n_cfg = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            n_cfg = cpa_pkg::ChunkBytesW'(1);
        end else if (i_cfg_wdata > cpa_pkg::ChunkBytesW'(cpa_pkg::ChunkBytesMax)) begin
            n_cfg = cpa_pkg::ChunkBytesW'(cpa_pkg::ChunkBytesMax);
        end
    end

    // free-run length ending at the scanned chunk, and the start it implies
    assign n_run   = r_busy[r_pos] ? '0 : r_run + 1'b1;
    assign n_start = r_pos - cpa_pkg::ChunkIdxW'(r_len - 1'b1);

    always_comb begin
        unique case (r_state)
            S_MUL_A: mul_a = cpa_pkg::RunLenW'(r_start);
            S_MUL_B: mul_a = r_len;
            S_MUL_U: mul_a = r_used;
            default: mul_a = '0;
        endcase
    end

    assign mul_p = mul_a * r_cb;
    assign n_ok  = (r_status == cpa_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MARK) begin
            r_run_mem[r_start] <= r_len;
        end
        r_run_rd <= r_run_mem[r_start];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cb       <= cpa_pkg::ChunkBytesW'(cpa_pkg::ChunkBytesReset);
            r_busy     <= '0;
            r_head_vld <= '0;
            r_cursor   <= '0;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cb <= n_cfg;
            end

            if (r_state == S_OUT && (!r_out_vld || i_out_ready)) begin
                r_out_vld             <= 1'b1;
                r_out.status          <= r_status;
                r_out.granted_address <= r_gaddr;
                r_out.granted_bytes   <= r_gbytes;
                r_out.used_bytes      <= r_ubytes;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_req_type <= i_in_data.req_type;
                        if (n_div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            r_status <= cpa_pkg::ST_ZERO;
                            r_state  <= S_MUL_A;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_req_type == cpa_pkg::REQ_ALLOC) begin
                            if (div_q > cpa_pkg::DivW'(cpa_pkg::NumChunks)) begin
                                r_status <= cpa_pkg::ST_NO_ROOM;
                                r_state  <= S_MUL_A;
                            end else begin
                                r_len     <= div_q[cpa_pkg::RunLenW-1:0];
                                r_pos     <= r_cursor;
                                r_run     <= '0;
                                r_wrapped <= 1'b0;
                                r_state   <= S_SCAN;
                            end
                        end else begin
                            if (div_r != '0 ||
                                div_q >= cpa_pkg::DivW'(cpa_pkg::NumChunks)) begin
                                r_status <= cpa_pkg::ST_BAD_FREE;
                                r_state  <= S_MUL_A;
                            end else begin
                                r_start <= div_q[cpa_pkg::ChunkIdxW-1:0];
                                r_state <= S_FREE_RD;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_run <= n_run;
                    if (n_run == r_len) begin
                        r_start             <= n_start;
                        r_pos               <= n_start;
                        r_left              <= r_len;
                        r_head_vld[n_start] <= 1'b1;
                        r_cursor            <= n_start;
                        r_used              <= r_used + r_len;
                        r_status            <= cpa_pkg::ST_OK;
                        r_state             <= S_MARK;
                    end else if (r_pos == cpa_pkg::ChunkIdxW'(cpa_pkg::NumChunks - 1)) begin
                        // wrap once to cover the chunks below the cursor
                        if (!r_wrapped && r_cursor != '0) begin
                            r_wrapped <= 1'b1;
                            r_pos     <= '0;
                            r_run     <= '0;
                        end else begin
                            r_status <= cpa_pkg::ST_NO_ROOM;
                            r_state  <= S_MUL_A;
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_MARK: begin
                    r_busy[r_pos] <= 1'b1;
                    r_pos         <= r_pos + 1'b1;
                    r_left        <= r_left - 1'b1;
                    if (r_left == cpa_pkg::RunLenW'(1)) begin
                        r_state <= S_MUL_A;
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (!r_head_vld[r_start]) begin
                        r_status <= cpa_pkg::ST_BAD_FREE;
                        r_state  <= S_MUL_A;
                    end else begin
                        r_len               <= r_run_rd;
                        r_left              <= r_run_rd;
                        r_pos               <= r_start;
                        r_head_vld[r_start] <= 1'b0;
                        r_used              <= (r_used >= r_run_rd) ? r_used - r_run_rd : '0;
                        r_status            <= cpa_pkg::ST_OK;
                        r_state             <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_busy[r_pos] <= 1'b0;
                    r_pos         <= r_pos + 1'b1;
                    r_left        <= r_left - 1'b1;
                    if (r_left == cpa_pkg::RunLenW'(1)) begin
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    r_gaddr <= (n_ok && r_req_type == cpa_pkg::REQ_ALLOC)
                               ? mul_p[cpa_pkg::AddrW-1:0] : '0;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_gbytes <= n_ok ? mul_p[cpa_pkg::BytesW-1:0] : '0;
                    r_state  <= S_MUL_U;
                end
                S_MUL_U: begin
                    r_ubytes <= mul_p[cpa_pkg::BytesW-1:0];
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    // hold until the previous response has been taken
                    if (!r_out_vld || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/cpa_div.sv @@
module cpa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cpa_pkg::DivW-1:0]          i_dividend,
    input  logic [cpa_pkg::ChunkBytesW-1:0]   i_divisor,
    output logic                              o_done,
    output logic [cpa_pkg::DivW-1:0]          o_quotient,
    output logic [cpa_pkg::ChunkBytesW-1:0]   o_remainder
);

    logic                            r_busy;
    logic                            r_done;
    logic [cpa_pkg::DivCntW-1:0]     r_cnt;
    logic [cpa_pkg::DivW-1:0]        r_num;
    logic [cpa_pkg::ChunkBytesW-1:0] r_rem;

    logic [cpa_pkg::ChunkBytesW:0]   n_trial;
    logic [cpa_pkg::ChunkBytesW:0]   n_diff;
    logic                            n_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_num[cpa_pkg::DivW-1]};
        n_diff  = n_trial - {1'b0, i_divisor};
        n_ge    = (n_trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[cpa_pkg::ChunkBytesW-1:0]
                              : n_trial[cpa_pkg::ChunkBytesW-1:0];
                r_num <= {r_num[cpa_pkg::DivW-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cpa_pkg::DivCntW'(cpa_pkg::DivW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_num;
    assign o_remainder = r_rem;

endmodule
